// ----- rtl/irtm_pkg.sv -----
// Shared types and constants for the IP range table matcher.
`timescale 1ns / 1ps
package irtm_pkg;

	localparam int MAX_RANGES  = 16;
	localparam int CNT_W       = $clog2(MAX_RANGES + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int USED_W      = 5;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_APPEND = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	// Decoded request. IPv4 masks are already cut down to bits 31:0.
	typedef struct packed {
		op_t          op;
		logic         v6;
		logic [127:0] addr;
		logic [127:0] mask;
	} cmd_t;

	typedef struct packed {
		logic         v6;
		logic [127:0] addr;
		logic [127:0] mask;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/irtm_front.sv -----
// Front end: takes requests and decodes them into table commands.
`timescale 1ns / 1ps
module irtm_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic              is_ip,
	input  logic              is_ipv6,
	input  logic [63:0]       addr_hi,
	input  logic [63:0]       addr_lo,
	input  logic [63:0]       mask_hi,
	input  logic [63:0]       mask_lo,
	input  irtm_pkg::q_stat_t q_stat,
	output logic              push,
	output irtm_pkg::cmd_t    push_cmd
);
	import irtm_pkg::*;

	op_t op_c;

	always_comb begin
		unique case (func)
			FUNC_CLEAR:  op_c = OP_CLEAR;
			FUNC_APPEND: op_c = OP_APPEND;
			// a non-IP address can never hit, so it needs no table work
			FUNC_LOOKUP: op_c = is_ip ? OP_LOOKUP : OP_NONE;
			default:     op_c = OP_NONE;
		endcase
	end

	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		push_cmd.op   = op_c;
		push_cmd.v6   = is_ipv6;
		push_cmd.addr = {addr_hi, addr_lo};
		if (is_ipv6) begin
			push_cmd.mask = {mask_hi, mask_lo};
		end else begin
			push_cmd.mask = {96'd0, mask_lo[31:0]};
		end
	end

endmodule

// ----- rtl/irtm_queue.sv -----
// Short command queue between front end and back end.
`timescale 1ns / 1ps
module irtm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irtm_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output irtm_pkg::cmd_t    head_cmd,
	output irtm_pkg::q_stat_t q_stat
);
	import irtm_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   level_q;

	assign q_stat.full  = (level_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_stat.empty = (level_q == '0);
	assign head_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/irtm_back.sv -----
// Back end: range table, parallel compare and result register.
`timescale 1ns / 1ps
module irtm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  irtm_pkg::q_stat_t q_stat,
	input  irtm_pkg::cmd_t    head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              matched,
	output logic              status,
	output logic [4:0]        entries_used
);
	import irtm_pkg::*;

	entry_t                tbl_q [MAX_RANGES];
	logic [CNT_W-1:0]      cnt_q;

	logic                  valid_s1;
	logic [MAX_RANGES-1:0] hits_s1;
	logic                  status_s1;
	logic [CNT_W-1:0]      cnt_s1;

	logic                  ready_s2;
	logic                  ready_s1;
	logic                  full_c;
	logic                  wr_c;
	logic [MAX_RANGES-1:0] hits_c;
	logic [CNT_W-1:0]      cnt_c;

	assign ready_s2 = !out_valid || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pop      = ready_s1 && !q_stat.empty;

	assign full_c = (cnt_q == CNT_W'(MAX_RANGES));
	assign wr_c   = pop && (head_cmd.op == OP_APPEND) && !full_c;

	// every live entry compared at once; masks of IPv4 entries are zero above bit 31
	always_comb begin
		for (int k = 0; k < MAX_RANGES; k++) begin
			hits_c[k] = (head_cmd.op == OP_LOOKUP)
				&& (CNT_W'(k) < cnt_q)
				&& (tbl_q[k].v6 == head_cmd.v6)
				&& (((head_cmd.addr ^ tbl_q[k].addr) & tbl_q[k].mask) == '0);
		end
	end

	always_comb begin
		unique case (head_cmd.op)
			OP_CLEAR:  cnt_c = '0;
			OP_APPEND: cnt_c = full_c ? cnt_q : cnt_q + 1'b1;
			default:   cnt_c = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= cnt_c;
			end
			if (ready_s1) begin
				valid_s1 <= !q_stat.empty;
			end
			if (ready_s2) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RANGES; k++) begin
			if (wr_c && (cnt_q == CNT_W'(k))) begin
				tbl_q[k].v6   <= head_cmd.v6;
				tbl_q[k].addr <= head_cmd.addr;
				tbl_q[k].mask <= head_cmd.mask;
			end
		end
		if (pop) begin
			hits_s1   <= hits_c;
			status_s1 <= (head_cmd.op == OP_APPEND) && full_c;
			cnt_s1    <= cnt_c;
		end
		if (ready_s2 && valid_s1) begin
			matched      <= |hits_s1;
			status       <= status_s1;
			entries_used <= USED_W'(cnt_s1);
		end
	end

endmodule

// ----- rtl/ip_range_table_match.sv -----
// Path: queue slot, then compare stage (every stored range in parallel), then output register.
// Throughput: one request per cycle while out_ready does not hold the output register.
// Append, clear and count update happen at the compare stage, in request order.
// Reset (arst_n low, asynchronous): table empty, queue and pipeline empty, out_valid low.
// Range storage itself is not reset; only entries below the count are ever compared.
`timescale 1ns / 1ps
module ip_range_table_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        is_ip,
	input  logic        is_ipv6,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic [63:0] mask_hi,
	input  logic [63:0] mask_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic        status,
	output logic [4:0]  entries_used
);
	import irtm_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head_cmd;

	irtm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.is_ip    (is_ip),
		.is_ipv6  (is_ipv6),
		.addr_hi  (addr_hi),
		.addr_lo  (addr_lo),
		.mask_hi  (mask_hi),
		.mask_lo  (mask_lo),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	irtm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	irtm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.matched      (matched),
		.status       (status),
		.entries_used (entries_used)
	);

`ifndef SYNTHESIS
	a_refused_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && status))
		else $error("refused append reported a hit");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> (!in_ready && !q_stat.empty))
		else $error("request taken while queue full");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_stat.empty)
		else $error("queue empty after push");
`endif

endmodule

// ----- tb/tb_ip_range_table_match.sv -----
// Self-checking testbench for the IP range table matcher.
`timescale 1ns / 1ps
module tb_ip_range_table_match;
	import irtm_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_REQS = 1830;

	typedef struct {
		logic [1:0]  func;
		logic        is_ip;
		logic        is_ipv6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [63:0] mask_hi;
		logic [63:0] mask_lo;
		logic        hold_for_drain;
	} request_t;

	typedef struct {
		logic       matched;
		logic       status;
		logic [4:0] entries_used;
	} table_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic        is_ip = 1'b0;
	logic        is_ipv6 = 1'b0;
	logic [63:0] addr_hi = '0;
	logic [63:0] addr_lo = '0;
	logic [63:0] mask_hi = '0;
	logic [63:0] mask_lo = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        matched;
	logic        status;
	logic [4:0]  entries_used;

	ip_range_table_match u_dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	request_t      pending_reqs[$];
	table_result_t expected_results[$];
	int            fail_count = 0;
	int            results_seen = 0;
	int            idle_cycles = 0;
	bit            req_taken = 1'b0;
	bit            resp_taken = 1'b0;

	// Shadow of the range table as the block should hold it.
	logic [127:0] tbl_addr [MAX_RANGES];
	logic [127:0] tbl_mask [MAX_RANGES];
	logic         tbl_v6 [MAX_RANGES];
	int           tbl_count = 0;

	function automatic table_result_t classify_request(input request_t r);
		table_result_t res;
		logic [127:0]  a;
		logic [127:0]  diff;
		res = '{1'b0, 1'b0, 5'd0};
		a = {r.addr_hi, r.addr_lo};
		case (r.func)
			FUNC_CLEAR: tbl_count = 0;
			FUNC_APPEND: begin
				if (tbl_count >= MAX_RANGES) begin
					res.status = 1'b1;
				end else begin
					tbl_addr[tbl_count] = a;
					tbl_mask[tbl_count] = {r.mask_hi, r.mask_lo};
					tbl_v6[tbl_count] = r.is_ipv6;
					tbl_count++;
				end
			end
			FUNC_LOOKUP: begin
				if (r.is_ip) begin
					for (int k = 0; k < tbl_count; k++) begin
						diff = (a ^ tbl_addr[k]) & tbl_mask[k];
						// IPv4 only looks at bits 31:0 of the low half
						if (tbl_v6[k] == r.is_ipv6 && (r.is_ipv6 ? diff == '0 : diff[31:0] == '0))
							res.matched = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.entries_used = tbl_count[4:0];
		return res;
	endfunction

	// Request driver
	int       send_gap = 0;
	bit       send_fast = 1'b0;
	request_t next_req;

	always @(negedge clk) begin : drive_requests
		logic v;
		v = in_valid;
		if (req_taken) begin
			req_taken = 1'b0;
			v = 1'b0;
			if ($urandom_range(0, 39) == 0)
				send_fast = !send_fast;
			send_gap = send_fast ? 0 : $urandom_range(0, 9);
		end
		if (arst_n && !v) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].hold_for_drain && expected_results.size() != 0)) begin
				next_req = pending_reqs.pop_front();
				func <= next_req.func;
				is_ip <= next_req.is_ip;
				is_ipv6 <= next_req.is_ipv6;
				addr_hi <= next_req.addr_hi;
				addr_lo <= next_req.addr_lo;
				mask_hi <= next_req.mask_hi;
				mask_lo <= next_req.mask_lo;
				v = 1'b1;
			end
		end
		in_valid <= v;
	end

	// Result receiver backpressure
	int recv_stall = 0;
	bit recv_fast = 1'b0;

	always @(negedge clk) begin : drive_ready
		if (resp_taken) begin
			resp_taken = 1'b0;
			if ($urandom_range(0, 39) == 0)
				recv_fast = !recv_fast;
			recv_stall = recv_fast ? 0 : $urandom_range(0, 9);
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predict on request accept, compare on result accept
	always @(posedge clk) begin : check_results
		request_t      seen;
		table_result_t want;
		bit            progress;
		progress = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen = '{func, is_ip, is_ipv6, addr_hi, addr_lo, mask_hi, mask_lo, 1'b0};
				expected_results.push_back(classify_request(seen));
				req_taken = 1'b1;
				progress = 1'b1;
			end
			if (out_valid && out_ready) begin
				resp_taken = 1'b1;
				progress = 1'b1;
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: matched %0d status %0d entries_used %0d",
						matched, status, entries_used);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (matched !== want.matched) begin
						$error("matched: expected %0d, got %0d", want.matched, matched);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (entries_used !== want.entries_used) begin
						$error("entries_used: expected %0d, got %0d",
							want.entries_used, entries_used);
						fail_count++;
					end
				end
			end
			if (progress) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// Stimulus generation; keeps its own view of what the table holds so that
	// lookups can be aimed at stored ranges.
	logic [127:0] gen_addr [MAX_RANGES];
	logic [127:0] gen_mask [MAX_RANGES];
	logic         gen_v6 [MAX_RANGES];
	int           gen_count = 0;
	int           reqs_queued = 0;
	bit           drain_next = 1'b0;

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic push_req(input logic [1:0] f, input logic ip, input logic v6,
			input logic [127:0] a, input logic [127:0] m);
		request_t r;
		r.func = f;
		r.is_ip = ip;
		r.is_ipv6 = v6;
		{r.addr_hi, r.addr_lo} = a;
		{r.mask_hi, r.mask_lo} = m;
		r.hold_for_drain = drain_next;
		drain_next = 1'b0;
		pending_reqs.push_back(r);
		reqs_queued++;
		if (f == FUNC_CLEAR) begin
			gen_count = 0;
		end else if (f == FUNC_APPEND && gen_count < MAX_RANGES) begin
			gen_addr[gen_count] = a;
			gen_mask[gen_count] = m;
			gen_v6[gen_count] = v6;
			gen_count++;
		end
	endtask

	function automatic logic [127:0] pick_mask(input logic v6);
		int           len;
		logic [127:0] r;
		r = rand128();
		len = v6 ? $urandom_range(0, 128) : $urandom_range(0, 32);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return r;
			default: begin
				if (v6)
					return ~({128{1'b1}} >> len);
				return {r[127:32], ~(32'hFFFF_FFFF >> len)};
			end
		endcase
	endfunction

	initial begin : stimulus
		logic [127:0] a;
		logic [127:0] m;
		logic [127:0] ones;
		logic         v6;
		int           n;
		int           lookups;
		int           k;
		ones = '1;

		// directed
		push_req(FUNC_LOOKUP, 1'b1, 1'b1, ones, ones);
		push_req(FUNC_UNUSED, 1'b1, 1'b1, ones, ones);
		// 10.0.0.0/8 with junk in the bits an IPv4 range ignores
		push_req(FUNC_APPEND, 1'b0, 1'b0, {ones[127:32], 32'h0A00_0000},
			{ones[127:32], 32'hFF00_0000});
		push_req(FUNC_LOOKUP, 1'b1, 1'b0, 128'h0A01_0203, '0);
		push_req(FUNC_LOOKUP, 1'b0, 1'b0, 128'h0A01_0203, '0);
		push_req(FUNC_LOOKUP, 1'b1, 1'b1, 128'h0A01_0203, '0);
		push_req(FUNC_APPEND, 1'b0, 1'b1, ones, ones);
		push_req(FUNC_LOOKUP, 1'b1, 1'b1, ones, ones);
		// fill the table, then one more append that must be refused
		for (int i = 2; i < MAX_RANGES; i++)
			push_req(FUNC_APPEND, 1'b1, i[0], '0, (i == 2) ? '0 : ones << i);
		push_req(FUNC_APPEND, 1'b0, 1'b0, ones, ones);
		push_req(FUNC_LOOKUP, 1'b1, 1'b0, 128'hDEAD_BEEF, '0);
		drain_next = 1'b1;
		push_req(FUNC_CLEAR, 1'b1, 1'b1, ones, ones);
		push_req(FUNC_LOOKUP, 1'b1, 1'b0, 128'h0A01_0203, '0);

		// random: clear, load a set of ranges, then probe it
		drain_next = 1'b1;
		while (reqs_queued < TARGET_REQS) begin
			if ($urandom_range(0, 9) == 0)
				drain_next = 1'b1;
			push_req(FUNC_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				rand128(), rand128());
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, MAX_RANGES + 3)
				: $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				v6 = 1'($urandom_range(0, 1));
				push_req(FUNC_APPEND, 1'($urandom_range(0, 1)), v6, rand128(),
					pick_mask(v6));
			end
			lookups = $urandom_range(4, 20);
			for (int i = 0; i < lookups; i++) begin
				case ($urandom_range(0, 19))
					0: push_req(FUNC_UNUSED, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), rand128(), rand128());
					1: begin
						v6 = 1'($urandom_range(0, 1));
						push_req(FUNC_APPEND, 1'($urandom_range(0, 1)), v6, rand128(),
							pick_mask(v6));
					end
					2, 3, 4, 5: push_req(FUNC_LOOKUP, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), rand128(), rand128());
					default: begin
						if (gen_count == 0) begin
							push_req(FUNC_LOOKUP, 1'b1, 1'($urandom_range(0, 1)),
								rand128(), rand128());
						end else begin
							k = $urandom_range(0, gen_count - 1);
							m = gen_mask[k];
							a = (gen_addr[k] & m) | (rand128() & ~m);
							// near miss: flip one bit within the width of the address family
							if ($urandom_range(0, 3) == 0) begin
								n = gen_v6[k] ? $urandom_range(0, 127) : $urandom_range(0, 31);
								a[n] = !a[n];
							end
							v6 = gen_v6[k] ^ ($urandom_range(0, 9) == 0);
							push_req(FUNC_LOOKUP, $urandom_range(0, 9) != 0, v6, a, rand128());
						end
					end
				endcase
			end
		end

		// every queued request must come back as a result
		while (results_seen < reqs_queued)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
